/* hw/rtl/pfx_pkg.sv */
// Shared types and constants of the postfix expression evaluator.
package pfx_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DATA_WIDTH  = 32;
  localparam int VALUE_W     = 32;
  localparam int CHAR_W      = 8;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ITER_W      = $clog2(DATA_WIDTH);

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef enum logic [1:0] {
    SEL_HOLD,
    SEL_PREV,
    SEL_NEXT
  } cell_sel_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_t;

  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  busy;
    logic  done;
    word_t quotient;
  } div_rsp_t;

endpackage

/* hw/rtl/pfx_cell.sv */
// One stack cell: holds an entry and loads from either neighbor.
module pfx_cell (
  input  logic              clk,
  input  pfx_pkg::cell_sel_t sel,
  input  pfx_pkg::word_t    prev_data,
  input  pfx_pkg::word_t    next_data,
  output pfx_pkg::word_t    data
);
  import pfx_pkg::*;

  always_ff @(posedge clk) begin
    case (sel)
      SEL_PREV: data <= prev_data;
      SEL_NEXT: data <= next_data;
      default:  data <= data;
    endcase
  end

endmodule

/* hw/rtl/pfx_div.sv */
// Iterative restoring divider on unsigned magnitudes, one quotient bit per cycle.
module pfx_div (
  input  logic              clk,
  input  logic              rst,
  input  pfx_pkg::div_req_t req,
  output pfx_pkg::div_rsp_t rsp
);
  import pfx_pkg::*;

  logic                  busy;
  logic                  done;
  logic [ITER_W-1:0]     iter;
  word_t                 rem;
  word_t                 quo;
  word_t                 dvs;
  logic [DATA_WIDTH:0]   rem_sh;
  logic [DATA_WIDTH:0]   diff;

  assign rem_sh = {rem, quo[DATA_WIDTH-1]};
  assign diff   = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        iter <= ITER_W'(DATA_WIDTH - 1);
        rem  <= '0;
        quo  <= req.dividend;
        dvs  <= req.divisor;
      end else if (busy) begin
        if (!diff[DATA_WIDTH]) begin
          rem <= diff[DATA_WIDTH-1:0];
          quo <= {quo[DATA_WIDTH-2:0], 1'b1};
        end else begin
          rem <= rem_sh[DATA_WIDTH-1:0];
          quo <= {quo[DATA_WIDTH-2:0], 1'b0};
        end
        iter <= iter - 1'b1;
        if (iter == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

/* hw/rtl/postfix_expression_evaluator_unit.sv */
// Top level of the postfix expression evaluator: control, arithmetic and cell stack.
//
//  channel | direction | tdata                  | tuser                              | tlast
//  s_*     | in        | [7:0] char_code        | -                                  | end_of_expression
//  m_*     | out       | [31:0] value           | [0] divide_by_zero [1] stack_overflow | -
//
// A digit or an ignored character is taken in idle; + - * pass through calculate and push;
// / also waits in divide on the one-bit-per-cycle divider, unless the divisor is zero. A
// final character then loads the result register in the finish state, waiting while a prior
// result stalls. The stack is a chain of cells that shift toward or away from the top.
// Reset clears the stack count and flags; cell contents are unspecified.
module postfix_expression_evaluator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tlast,   // end_of_expression
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] value
  output logic [1:0]  m_tuser    // [0] divide_by_zero, [1] stack_overflow
);
  import pfx_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_PUSH,
    ST_FINISH
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic              flag_div0;
  logic              flag_ovf;
  op_t               op;
  logic              last_r;
  word_t             left;
  word_t             right;
  word_t             res;
  logic              neg;

  word_t             cell_q [STACK_DEPTH];
  cell_sel_t         cell_sel [STACK_DEPTH];
  word_t             push_data;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic              accept;
  logic              is_digit;
  logic              is_op;
  logic [CHAR_W-1:0] digit;
  word_t             left_mag;
  word_t             right_mag;
  logic              out_free;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign is_digit = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
  assign is_op    = (s_tdata == CH_PLUS) || (s_tdata == CH_MINUS) ||
                    (s_tdata == CH_STAR) || (s_tdata == CH_SLASH);
  assign digit    = s_tdata - CH_ZERO;
  assign left_mag  = left[DATA_WIDTH-1]  ? (word_t'(0) - left)  : left;
  assign right_mag = right[DATA_WIDTH-1] ? (word_t'(0) - right) : right;
  assign out_free  = !m_tvalid || m_tready;

  always_comb begin
    push_data = DATA_WIDTH'(digit);
    for (int i = 0; i < STACK_DEPTH; i++) begin
      cell_sel[i] = SEL_HOLD;
    end
    if (state == ST_IDLE && accept && is_digit && (count < CNT_W'(STACK_DEPTH))) begin
      for (int i = 0; i < STACK_DEPTH; i++) begin
        cell_sel[i] = SEL_PREV;
      end
    end else if (state == ST_PUSH) begin
      push_data = res;
      if (count >= CNT_W'(2)) begin
        cell_sel[0] = SEL_PREV;
        for (int i = 1; i < STACK_DEPTH; i++) begin
          cell_sel[i] = SEL_NEXT;
        end
      end else if (count == CNT_W'(1)) begin
        cell_sel[0] = SEL_PREV;
      end else begin
        for (int i = 0; i < STACK_DEPTH; i++) begin
          cell_sel[i] = SEL_PREV;
        end
      end
    end
  end

  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    word_t prev_d;
    word_t next_d;
    if (g == 0) begin : g_first
      assign prev_d = push_data;
    end else begin : g_mid
      assign prev_d = cell_q[g-1];
    end
    if (g == STACK_DEPTH - 1) begin : g_last
      assign next_d = '0;
    end else begin : g_inner
      assign next_d = cell_q[g+1];
    end
    pfx_cell u_cell (
      .clk       (clk),
      .sel       (cell_sel[g]),
      .prev_data (prev_d),
      .next_data (next_d),
      .data      (cell_q[g])
    );
  end

  always_comb begin
    div_req.start    = (state == ST_CALC) && (op == OP_DIV) && (right != '0);
    div_req.dividend = left_mag;
    div_req.divisor  = right_mag;
  end

  pfx_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      flag_div0 <= 1'b0;
      flag_ovf  <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (m_tready && !(state == ST_FINISH && out_free)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            last_r <= s_tlast;
            if (is_digit) begin
              if (count < CNT_W'(STACK_DEPTH)) begin
                count <= count + 1'b1;
              end else begin
                flag_ovf <= 1'b1;
              end
              state <= s_tlast ? ST_FINISH : ST_IDLE;
            end else if (is_op) begin
              right <= (count >= CNT_W'(1)) ? cell_q[0] : '1;
              left  <= (count >= CNT_W'(2)) ? cell_q[1] : '1;
              case (s_tdata)
                CH_PLUS:  op <= OP_ADD;
                CH_MINUS: op <= OP_SUB;
                CH_STAR:  op <= OP_MUL;
                default:  op <= OP_DIV;
              endcase
              state <= ST_CALC;
            end else begin
              state <= s_tlast ? ST_FINISH : ST_IDLE;
            end
          end
        end
        ST_CALC: begin
          neg   <= left[DATA_WIDTH-1] ^ right[DATA_WIDTH-1];
          state <= ST_PUSH;
          unique case (op)
            OP_ADD: res <= left + right;
            OP_SUB: res <= left - right;
            OP_MUL: res <= word_t'(left * right);
            OP_DIV: begin
              if (right == '0) begin
                res       <= '0;
                flag_div0 <= 1'b1;
              end else begin
                state <= ST_DIV;
              end
            end
          endcase
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            res   <= neg ? (word_t'(0) - div_rsp.quotient) : div_rsp.quotient;
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (count >= CNT_W'(2)) begin
            count <= count - 1'b1;
          end else if (count == CNT_W'(0)) begin
            count <= CNT_W'(1);
          end
          state <= last_r ? ST_FINISH : ST_IDLE;
        end
        ST_FINISH: begin
          if (out_free) begin
            m_tvalid  <= 1'b1;
            m_tdata   <= (count != '0) ? VALUE_W'($signed(cell_q[0])) : '1;
            m_tuser   <= {flag_ovf, flag_div0};
            count     <= '0;
            flag_div0 <= 1'b0;
            flag_ovf  <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_full_push: assert property (@(posedge clk) disable iff (rst)
    (accept && is_digit && count == CNT_W'(STACK_DEPTH)) |=>
      (count == CNT_W'(STACK_DEPTH)) && flag_ovf)
    else $error("push onto full stack not dropped");

  a_result_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && out_free) |=>
      m_tvalid && count == '0 && !flag_div0 && !flag_ovf)
    else $error("expression end did not clear the stack");

  a_div_busy: assert property (@(posedge clk) disable iff (rst)
    div_rsp.busy |-> state == ST_DIV)
    else $error("divider busy outside divide state");

endmodule

/* verif/rpn_eval_checker.sv */
// Checker for the postfix evaluator: predicts each expression result and compares the output stream.
module rpn_eval_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tlast,   // end_of_expression
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // [31:0] value
  input  logic [1:0]  m_tuser,   // [0] divide_by_zero, [1] stack_overflow
  output int          fail_count,
  output int          pending
);
  import pfx_pkg::*;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               divide_by_zero;
    logic               stack_overflow;
  } rpn_result_t;

  localparam word_t MIN_WORD = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  word_t       operand_stack [STACK_DEPTH];
  int unsigned depth;
  logic        div0_flag;
  logic        ovf_flag;
  rpn_result_t awaited_results [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic word_t pop_operand();
    if (depth == 0) return '1;
    depth--;
    return operand_stack[depth];
  endfunction

  function automatic void push_operand(word_t v);
    if (depth >= STACK_DEPTH) begin
      ovf_flag = 1'b1;
    end else begin
      operand_stack[depth] = v;
      depth++;
    end
  endfunction

  function automatic word_t quotient_toward_zero(word_t num, word_t den);
    if (num == MIN_WORD && den == '1) return MIN_WORD;
    return word_t'($signed(num) / $signed(den));
  endfunction

  function automatic void evaluate_char(logic [7:0] c, logic last);
    word_t       rhs;
    word_t       lhs;
    word_t       res;
    op_t         op;
    bit          is_op;
    rpn_result_t r;
    is_op = 1'b1;
    op    = OP_ADD;
    case (c)
      CH_PLUS:  op = OP_ADD;
      CH_MINUS: op = OP_SUB;
      CH_STAR:  op = OP_MUL;
      CH_SLASH: op = OP_DIV;
      default:  is_op = 1'b0;
    endcase
    if (c >= CH_ZERO && c <= CH_NINE) begin
      push_operand(word_t'(c - CH_ZERO));
    end else if (is_op) begin
      rhs = pop_operand();
      lhs = pop_operand();
      case (op)
        OP_ADD: res = lhs + rhs;
        OP_SUB: res = lhs - rhs;
        OP_MUL: res = lhs * rhs;
        default: begin
          if (rhs == '0) begin
            div0_flag = 1'b1;
            res       = '0;
          end else begin
            res = quotient_toward_zero(lhs, rhs);
          end
        end
      endcase
      push_operand(res);
    end
    if (last) begin
      r.value          = VALUE_W'($signed(pop_operand()));
      r.divide_by_zero = div0_flag;
      r.stack_overflow = ovf_flag;
      awaited_results.push_back(r);
      depth     = 0;
      div0_flag = 1'b0;
      ovf_flag  = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    rpn_result_t want;
    if (rst) begin
      depth     = 0;
      div0_flag = 1'b0;
      ovf_flag  = 1'b0;
      awaited_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (awaited_results.size() == 0) begin
          $error("value: expected no result, actual %0d", $signed(m_tdata));
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (m_tdata !== want.value) begin
            $error("value: expected %0d, actual %0d", $signed(want.value), $signed(m_tdata));
            fail_count++;
          end
          if (m_tuser[0] !== want.divide_by_zero) begin
            $error("divide_by_zero: expected %0b, actual %0b", want.divide_by_zero, m_tuser[0]);
            fail_count++;
          end
          if (m_tuser[1] !== want.stack_overflow) begin
            $error("stack_overflow: expected %0b, actual %0b", want.stack_overflow, m_tuser[1]);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) evaluate_char(s_tdata, s_tlast);
    end
    pending = awaited_results.size();
  end

endmodule

/* verif/tb_postfix_expression_evaluator_unit.sv */
// Testbench top for the postfix evaluator: clock, reset, character stimulus, result stalls, verdict.
module tb_postfix_expression_evaluator_unit;
  import pfx_pkg::*;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;   // [7:0] char_code
  logic        s_tlast  = 1'b0; // end_of_expression
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // [31:0] value
  logic [1:0]  m_tuser;         // [0] divide_by_zero, [1] stack_overflow

  int fail_count;
  int pending;
  int chars_sent = 0;
  bit calm       = 1'b0;

  postfix_expression_evaluator_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  rpn_eval_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // stall the result side: short holds mostly, a few long ones, and free-running stretches
  initial begin
    int  hold;
    int  r;
    bit  level;
    hold  = 0;
    level = 1'b1;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          level = 1'b1;
          hold  = $urandom_range(100, 300);
        end else if (r < 60) begin
          level = 1'b1;
          hold  = $urandom_range(0, 4);
        end else if (r < 95) begin
          level = 1'b0;
          hold  = $urandom_range(0, 3);
        end else begin
          level = 1'b0;
          hold  = $urandom_range(10, 50);
        end
      end
      m_tready <= level;
    end
  end

  function automatic bit is_operator(logic [7:0] c);
    return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH;
  endfunction

  function automatic bit is_ignored(logic [7:0] c);
    return !(c >= CH_ZERO && c <= CH_NINE) && !is_operator(c);
  endfunction

  function automatic logic [7:0] digit_char(int unsigned n);
    return CH_ZERO + 8'(n);
  endfunction

  function automatic logic [7:0] random_operator();
    case ($urandom_range(0, 3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  function automatic logic [7:0] random_ignored();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (!is_ignored(c));
    return c;
  endfunction

  task automatic feed_char(input logic [7:0] c, input bit last);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) gap = 0;
    else if (r < 90)    gap = $urandom_range(1, 3);
    else if (r < 98)    gap = $urandom_range(4, 10);
    else                gap = $urandom_range(20, 60);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    chars_sent++;
  endtask

  task automatic feed_run(ref logic [7:0] text[$]);
    foreach (text[i]) feed_char(text[i], i == text.size() - 1);
  endtask

  task automatic build_wellformed(ref logic [7:0] text[$], input int operands,
                                  input int push_bias, input bit noisy);
    int pushed;
    int level;
    pushed = 0;
    level  = 0;
    while (pushed < operands || level > 1) begin
      if (noisy && $urandom_range(0, 5) == 0) text.push_back(random_ignored());
      if (pushed < operands && (level < 2 || $urandom_range(0, push_bias) != 0)) begin
        text.push_back(digit_char($urandom_range(0, 9)));
        pushed++;
        level++;
      end else begin
        text.push_back(random_operator());
        level--;
      end
    end
  endtask

  // leave the most negative word on the stack: 8^10 * 2
  task automatic build_min_word(ref logic [7:0] text[$]);
    repeat (10) text.push_back(digit_char(8));
    text.push_back(digit_char(2));
    repeat (10) text.push_back(CH_STAR);
  endtask

  task automatic feed_binary(input int unsigned a, input int unsigned b, input logic [7:0] op);
    feed_char(digit_char(a), 1'b0);
    feed_char(digit_char(b), 1'b0);
    feed_char(op, 1'b1);
  endtask

  initial begin
    logic [7:0] text[$];
    int         r;
    int         goal;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    feed_char(8'h00, 1'b1);
    feed_char(8'hFF, 1'b0);
    feed_char(digit_char(9), 1'b1);
    feed_char(CH_PLUS, 1'b1);
    feed_binary(3, 4, CH_PLUS);
    feed_binary(3, 4, CH_MINUS);
    feed_binary(7, 8, CH_STAR);
    feed_binary(9, 3, CH_SLASH);
    feed_binary(5, 0, CH_SLASH);
    text = '{digit_char(0), digit_char(7), CH_MINUS, digit_char(2), CH_SLASH};
    feed_run(text);
    text.delete();
    build_min_word(text);
    text.push_back(digit_char(0));
    text.push_back(digit_char(1));
    text.push_back(CH_MINUS);
    text.push_back(CH_SLASH);
    feed_run(text);
    text.delete();
    repeat (STACK_DEPTH + 1) text.push_back(digit_char(9));
    text.push_back(CH_PLUS);
    feed_run(text);

    goal = chars_sent + 900;
    while (chars_sent < goal) begin
      calm = ($urandom_range(0, 9) == 0);
      text.delete();
      r = $urandom_range(0, 99);
      if (r < 70) begin
        if ($urandom_range(0, 29) == 0)
          build_wellformed(text, $urandom_range(60, 70), 50, 1'b0);
        else
          build_wellformed(text, $urandom_range(1, 6), 2, r % 3 == 0);
        if (r % 5 == 0) text.push_back(random_ignored());
      end else if (r < 82) begin
        build_wellformed(text, $urandom_range(1, 5), 2, 1'b0);
        if (r % 2 == 0) text.push_back(random_operator());
        else void'(text.pop_back());
        if (text.size() == 0) text.push_back(random_operator());
      end else if (r < 96) begin
        repeat ($urandom_range(1, 8)) text.push_back(8'($urandom_range(0, 255)));
      end else begin
        build_min_word(text);
        if (r % 2 == 0) begin
          text.push_back(digit_char(0));
          text.push_back(digit_char(1));
          text.push_back(CH_MINUS);
        end else begin
          text.push_back(digit_char($urandom_range(0, 9)));
        end
        text.push_back(random_operator());
      end
      feed_run(text);
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/pfx_pkg.sv
hw/rtl/pfx_cell.sv
hw/rtl/pfx_div.sv
hw/rtl/postfix_expression_evaluator_unit.sv
verif/rpn_eval_checker.sv
verif/tb_postfix_expression_evaluator_unit.sv
